// ----- design/ncfs_pkg.sv -----
`default_nettype none

package ncfs_pkg;

    // register selects for write items
    typedef enum logic [2:0] {
        SEL_CONTROL = 3'd0,
        SEL_PERIOD  = 3'd1,
        SEL_LENGTH  = 3'd2,
        SEL_ENABLE  = 3'd3,
        SEL_FRAME   = 3'd4
    } reg_sel_t;

    // item kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // frame sequencer step points
    localparam logic [14:0] FRAME_STEP1 = 15'd3729;
    localparam logic [14:0] FRAME_STEP2 = 15'd7457;
    localparam logic [14:0] FRAME_STEP3 = 15'd11186;
    localparam logic [14:0] FRAME_STEP4 = 15'd14915;
    localparam logic [14:0] FRAME_STEP5 = 15'd18641;

    localparam logic [3:0] DECAY_FULL = 4'd15;

    function automatic logic [11:0] period_lookup(input logic [3:0] idx);
        logic [11:0] val;
        case (idx)
            4'd0:    val = 12'd4;
            4'd1:    val = 12'd8;
            4'd2:    val = 12'd16;
            4'd3:    val = 12'd32;
            4'd4:    val = 12'd64;
            4'd5:    val = 12'd96;
            4'd6:    val = 12'd128;
            4'd7:    val = 12'd160;
            4'd8:    val = 12'd202;
            4'd9:    val = 12'd254;
            4'd10:   val = 12'd380;
            4'd11:   val = 12'd508;
            4'd12:   val = 12'd762;
            4'd13:   val = 12'd1016;
            4'd14:   val = 12'd2034;
            default: val = 12'd4068;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] length_lookup(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:    val = 8'd10;
            5'd1:    val = 8'd254;
            5'd2:    val = 8'd20;
            5'd3:    val = 8'd2;
            5'd4:    val = 8'd40;
            5'd5:    val = 8'd4;
            5'd6:    val = 8'd80;
            5'd7:    val = 8'd6;
            5'd8:    val = 8'd160;
            5'd9:    val = 8'd8;
            5'd10:   val = 8'd60;
            5'd11:   val = 8'd10;
            5'd12:   val = 8'd14;
            5'd13:   val = 8'd12;
            5'd14:   val = 8'd26;
            5'd15:   val = 8'd14;
            5'd16:   val = 8'd12;
            5'd17:   val = 8'd16;
            5'd18:   val = 8'd24;
            5'd19:   val = 8'd18;
            5'd20:   val = 8'd48;
            5'd21:   val = 8'd20;
            5'd22:   val = 8'd96;
            5'd23:   val = 8'd22;
            5'd24:   val = 8'd192;
            5'd25:   val = 8'd24;
            5'd26:   val = 8'd72;
            5'd27:   val = 8'd26;
            5'd28:   val = 8'd16;
            5'd29:   val = 8'd28;
            5'd30:   val = 8'd32;
            default: val = 8'd30;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- design/noise_channel_with_frame_sequencer.sv -----
`default_nettype none

// path: an accepted item passes the input register, then the result register, to its result
// throughput: one item per cycle while results are taken (the state update between the two
// registers is combinational); results may stall, the input register then holding one item
// reset: rst_n, asynchronous, active low; all voice and sequencer state returns to its
// power-up values (lfsr to one, everything else to zero), both channels empty
module noise_channel_with_frame_sequencer
    import ncfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic       mode,
    input  wire logic [2:0] reg_select,
    input  wire logic [7:0] write_data,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [3:0] level,
    output      logic       length_active
);

    // input register
    logic       item_valid_reg;
    logic       item_mode_reg;
    logic [2:0] item_sel_reg;
    logic [7:0] item_data_reg;

    // voice state
    logic [7:0]  control_reg,   control_next;
    logic [11:0] reload_reg,    reload_next;
    logic [11:0] period_reg,    period_next;
    logic [7:0]  length_reg,    length_next;
    logic        restart_reg,   restart_next;
    logic [3:0]  divider_reg,   divider_next;
    logic [3:0]  decay_reg,     decay_next;
    logic [14:0] shift_reg,     shift_next;
    logic        enabled_reg,   enabled_next;
    logic        five_step_reg, five_step_next;
    logic [14:0] frame_reg,     frame_next;

    // result register
    logic       out_valid_reg;
    logic [3:0] level_reg,  level_next;
    logic       active_reg, active_next;

    logic        advance;
    logic        quarter;
    logic        half;
    logic [14:0] frame_inc;
    logic        feedback;

    // the stored item moves on when the result register is free or being emptied
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign length_active = active_reg;

    assign frame_inc = frame_reg + 15'd1;
    // short mode taps bit 6, long mode bit 1
    assign feedback  = shift_reg[0] ^ (control_reg[7] ? shift_reg[6] : shift_reg[1]);

    // frame sequencer strobes for this item
    always_comb
    begin
        quarter    = 1'b0;
        half       = 1'b0;
        frame_next = frame_reg;
        if (item_mode_reg == MODE_TICK)
        begin
            frame_next = frame_inc;
            if (frame_inc == FRAME_STEP1 || frame_inc == FRAME_STEP3)
            begin
                quarter = 1'b1;
            end
            else if (frame_inc == FRAME_STEP2)
            begin
                quarter = 1'b1;
                half    = 1'b1;
            end
            else if (frame_inc == FRAME_STEP4)
            begin
                if (!five_step_reg)
                begin
                    quarter    = 1'b1;
                    half       = 1'b1;
                    frame_next = '0;
                end
            end
            else if (frame_inc == FRAME_STEP5 && five_step_reg)
            begin
                quarter    = 1'b1;
                half       = 1'b1;
                frame_next = '0;
            end
        end
        else if (reg_sel_t'(item_sel_reg) == SEL_FRAME)
        begin
            // five-step mode clocks both at once on the write
            frame_next = '0;
            quarter    = item_data_reg[7];
            half       = item_data_reg[7];
        end
    end

    // state update
    always_comb
    begin
        control_next   = control_reg;
        reload_next    = reload_reg;
        period_next    = period_reg;
        length_next    = length_reg;
        restart_next   = restart_reg;
        divider_next   = divider_reg;
        decay_next     = decay_reg;
        shift_next     = shift_reg;
        enabled_next   = enabled_reg;
        five_step_next = five_step_reg;

        // envelope
        if (quarter)
        begin
            if (restart_reg)
            begin
                restart_next = 1'b0;
                decay_next   = DECAY_FULL;
                divider_next = control_reg[3:0];
            end
            else if (divider_reg == 4'd0)
            begin
                divider_next = control_reg[3:0];
                if (decay_reg != 4'd0)
                    decay_next = decay_reg - 4'd1;
                else if (control_reg[5])
                    decay_next = DECAY_FULL;
            end
            else
            begin
                divider_next = divider_reg - 4'd1;
            end
        end

        // length counter, held while halt is set
        if (half && !control_reg[5] && length_reg != 8'd0)
            length_next = length_reg - 8'd1;

        if (item_mode_reg == MODE_TICK)
        begin
            // period divider and lfsr
            if (period_reg == 12'd0)
            begin
                period_next = reload_reg;
                shift_next  = {feedback, shift_reg[14:1]};
            end
            else
            begin
                period_next = period_reg - 12'd1;
            end
        end
        else
        begin
            case (reg_sel_t'(item_sel_reg))
                SEL_CONTROL:
                begin
                    // bit 7 is the short-mode flag, kept
                    control_next = {control_reg[7], item_data_reg[6:0]};
                    restart_next = 1'b1;
                end
                SEL_PERIOD:
                begin
                    reload_next  = period_lookup(item_data_reg[3:0]);
                    control_next = {item_data_reg[7], control_reg[6:0]};
                end
                SEL_LENGTH:
                begin
                    if (enabled_reg)
                        length_next = length_lookup(item_data_reg[7:3]);
                    restart_next = 1'b1;
                end
                SEL_ENABLE:
                begin
                    enabled_next = item_data_reg[3];
                    if (!item_data_reg[3])
                        length_next = '0;
                end
                SEL_FRAME:
                begin
                    five_step_next = item_data_reg[7];
                end
                default:
                begin
                end
            endcase
        end
    end

    // result from the updated state
    always_comb
    begin
        active_next = enabled_next && (length_next != 8'd0);
        level_next  = '0;
        if (active_next && !shift_next[0])
            level_next = control_next[4] ? control_next[3:0] : decay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            control_reg    <= '0;
            reload_reg     <= '0;
            period_reg     <= '0;
            length_reg     <= '0;
            restart_reg    <= 1'b0;
            divider_reg    <= '0;
            decay_reg      <= '0;
            shift_reg      <= 15'd1;
            enabled_reg    <= 1'b0;
            five_step_reg  <= 1'b0;
            frame_reg      <= '0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                control_reg   <= control_next;
                reload_reg    <= reload_next;
                period_reg    <= period_next;
                length_reg    <= length_next;
                restart_reg   <= restart_next;
                divider_reg   <= divider_next;
                decay_reg     <= decay_next;
                shift_reg     <= shift_next;
                enabled_reg   <= enabled_next;
                five_step_reg <= five_step_next;
                frame_reg     <= frame_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_mode_reg <= mode;
            item_sel_reg  <= reg_select;
            item_data_reg <= write_data;
        end
        if (advance)
        begin
            level_reg  <= level_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ----- verif/noise_channel_with_frame_sequencer_tb.sv -----
module noise_channel_with_frame_sequencer_tb
    import ncfs_pkg::*;
();

    // selects the block does not decode, a write to them must change nothing
    localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
    localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

    // cycles with no item moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // settling time once the last result is in (two-stage pipeline plus margin)
    localparam int SETTLE_CYCLES = 8;

    // noise period table, entry 15 first so that entry i sits at [i*12 +: 12]
    localparam logic [16*12-1:0] NOISE_PERIODS = {
        12'd4068, 12'd2034, 12'd1016, 12'd762, 12'd508, 12'd380, 12'd254, 12'd202,
        12'd160,  12'd128,  12'd96,   12'd64,  12'd32,  12'd16,  12'd8,   12'd4
    };

    // length counter load table, entry 31 first so that entry i sits at [i*8 +: 8]
    localparam logic [32*8-1:0] LENGTH_LOADS = {
        8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
        8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
        8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8,  8'd160,
        8'd6,  8'd80, 8'd4,  8'd40, 8'd2,  8'd20, 8'd254, 8'd10
    };

    typedef struct packed {
        logic [3:0] level;
        logic       active;
    } voice_out_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       mode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] level;
    logic       length_active;

    noise_channel_with_frame_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .reg_select    (reg_select),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .length_active (length_active)
    );

    always #5 clk = ~clk;

    // voice state as the testbench expects it
    logic [7:0]  ctl_reg;          // bit7 short mode, bit5 halt/loop, bit4 constant volume
    logic [11:0] period_load;
    logic [11:0] period_left;
    logic [7:0]  length_left;
    logic        env_start;
    logic [3:0]  env_div;
    logic [3:0]  env_decay;
    logic [14:0] noise_lfsr;
    logic        voice_on;
    logic        five_step_mode;
    logic [14:0] seq_cycle;

    voice_out_t voice_expect_q[$];

    // run bookkeeping
    bit bursts_on;
    int items_sent;
    int results_checked;
    int mismatches;
    int env_clocks;
    int len_clocks;
    int lfsr_shifts;
    int hold_left;
    int stall_cycles;

    // ------------------------------------------------------------------
    // voice predictor
    // ------------------------------------------------------------------

    // quarter frame: envelope restart, divider and decay
    function automatic void envelope_clock();
        env_clocks++;
        if (env_start)
        begin
            env_start = 1'b0;
            env_decay = DECAY_FULL;
            env_div   = ctl_reg[3:0];
        end
        else if (env_div == 4'd0)
        begin
            env_div = ctl_reg[3:0];
            if (env_decay != 4'd0)
                env_decay = env_decay - 4'd1;
            else if (ctl_reg[5])
                env_decay = DECAY_FULL;
        end
        else
        begin
            env_div = env_div - 4'd1;
        end
    endfunction

    // half frame: length counter, frozen by the halt bit
    function automatic void length_clock();
        len_clocks++;
        if (!ctl_reg[5] && length_left != 8'd0)
            length_left = length_left - 8'd1;
    endfunction

    // period divider, lfsr steps on reload
    function automatic void noise_timer();
        logic fb;
        if (period_left == 12'd0)
        begin
            period_left = period_load;
            fb = ctl_reg[7] ? (noise_lfsr[0] ^ noise_lfsr[6])
                            : (noise_lfsr[0] ^ noise_lfsr[1]);
            noise_lfsr = {fb, noise_lfsr[14:1]};
            lfsr_shifts++;
        end
        else
        begin
            period_left = period_left - 12'd1;
        end
    endfunction

    // frame sequencer advance for one cpu cycle
    function automatic void sequencer_tick();
        seq_cycle = seq_cycle + 15'd1;
        if (seq_cycle == FRAME_STEP1 || seq_cycle == FRAME_STEP3)
        begin
            envelope_clock();
        end
        else if (seq_cycle == FRAME_STEP2)
        begin
            envelope_clock();
            length_clock();
        end
        else if (seq_cycle == FRAME_STEP4)
        begin
            if (!five_step_mode)
            begin
                envelope_clock();
                length_clock();
                seq_cycle = '0;
            end
        end
        else if (seq_cycle == FRAME_STEP5 && five_step_mode)
        begin
            envelope_clock();
            length_clock();
            seq_cycle = '0;
        end
    endfunction

    function automatic void register_write(input logic [2:0] sel, input logic [7:0] data);
        case (sel)
            SEL_CONTROL:
            begin
                ctl_reg   = {ctl_reg[7], data[6:0]};
                env_start = 1'b1;
            end
            SEL_PERIOD:
            begin
                period_load = NOISE_PERIODS[data[3:0]*12 +: 12];
                ctl_reg[7]  = data[7];
            end
            SEL_LENGTH:
            begin
                if (voice_on)
                    length_left = LENGTH_LOADS[data[7:3]*8 +: 8];
                env_start = 1'b1;
            end
            SEL_ENABLE:
            begin
                voice_on = data[3];
                if (!voice_on)
                    length_left = '0;
            end
            SEL_FRAME:
            begin
                five_step_mode = data[7];
                seq_cycle      = '0;
                if (five_step_mode)
                begin
                    length_clock();
                    envelope_clock();
                end
            end
            default: ;
        endcase
    endfunction

    // apply one accepted item and queue the result it must produce
    function automatic void voice_step(input logic kind, input logic [2:0] sel,
                                       input logic [7:0] data);
        voice_out_t res;
        if (kind == MODE_TICK)
        begin
            sequencer_tick();
            noise_timer();
        end
        else
        begin
            register_write(sel, data);
        end
        res.active = voice_on && (length_left != 8'd0);
        res.level  = '0;
        if (res.active && !noise_lfsr[0])
            res.level = ctl_reg[4] ? ctl_reg[3:0] : env_decay;
        voice_expect_q.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // item sender
    // ------------------------------------------------------------------

    // drives one item from a falling edge, with an occasional idle burst in front,
    // and holds it until it is taken
    task automatic push_item(input logic kind, input logic [2:0] sel, input logic [7:0] data);
        int gap;
        @(negedge clk);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= kind;
        reg_select <= sel;
        write_data <= data;
        do
            @(posedge clk);
        while (!in_ready);
        voice_step(kind, sel, data);
        items_sent++;
    endtask

    task automatic cpu_write(input logic [2:0] sel, input logic [7:0] data);
        push_item(MODE_WRITE, sel, data);
    endtask

    // select and data are don't-care on a tick, so they get junk
    task automatic cpu_tick();
        push_item(MODE_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (voice_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver back-pressure in bursts of random length
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            hold_left <= $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        voice_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (voice_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: level=%0d length_active=%0b",
                             $realtime, level, length_active);
            end
            else
            begin
                want = voice_expect_q.pop_front();
                if (want.level !== level || want.active !== length_active)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] result %0d: level exp %0d got %0d, ",
                                  "active exp %0b got %0b"},
                                 $realtime, results_checked, want.level, level,
                                 want.active, length_active);
                end
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, voice_expect_q.size());
                $display("FAIL noise_channel_with_frame_sequencer");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, every register, and the corner cases of the write decode
    task automatic test_directed_registers();
        int s;
        cpu_tick();                          // silent out of reset
        cpu_write(SEL_LENGTH, 8'hFF);        // disabled: no load, envelope restart still armed
        cpu_write(SEL_ENABLE, 8'hFF);
        cpu_write(SEL_LENGTH, 8'hFF);        // top length index
        cpu_write(SEL_CONTROL, 8'hFF);       // constant volume 15, halt; bit7 must be dropped
        cpu_write(SEL_PERIOD, 8'h00);        // shortest period, long lfsr mode
        repeat (6) cpu_tick();               // at least one lfsr step
        cpu_write(SEL_PERIOD, 8'hFF);        // longest period, short lfsr mode
        cpu_write(SEL_CONTROL, 8'h00);       // short-mode bit must survive a control write
        cpu_write(SEL_FRAME, 8'h80);         // five-step: quarter and half frame at once
        cpu_write(SEL_FRAME, 8'h7F);         // back to four-step
        for (s = SEL_SPARE_FIRST; s <= SEL_SPARE_LAST; s++)
            cpu_write(3'(s), 8'hFF);         // undecoded selects leave everything alone
        cpu_write(SEL_ENABLE, 8'hF7);        // disable clears the length counter
        cpu_write(SEL_ENABLE, 8'h08);
        cpu_write(SEL_LENGTH, 8'h07);        // bottom length index
        cpu_write(SEL_CONTROL, 8'h10);       // constant volume 0
        repeat (2) cpu_tick();
    endtask

    // mostly well-formed set-ups followed by tick runs, with five-step writes
    // standing in for quarter and half frames, plus stray writes as noise
    task automatic test_random_sequences(input int budget);
        int stop_at;
        int run;
        int k;
        logic [7:0] d;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                d = 8'($urandom_range(0, 255));
                d[3] = ($urandom_range(0, 7) != 0);
                cpu_write(SEL_ENABLE, d);
                // mostly short periods so the lfsr actually moves
                d = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0)
                    d[3:0] = 4'($urandom_range(0, 4));
                cpu_write(SEL_PERIOD, d);
                cpu_write(SEL_CONTROL, 8'($urandom_range(0, 255)));
                cpu_write(SEL_LENGTH, 8'($urandom_range(0, 255)));
            end
            run = $urandom_range(5, 60);
            for (k = 0; k < run; k++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                    begin
                        d = 8'($urandom_range(0, 255));
                        d[7] = 1'b1;
                        cpu_write(SEL_FRAME, d);
                    end
                    3:
                    begin
                        d = 8'($urandom_range(0, 255));
                        d[7] = 1'b0;
                        cpu_write(SEL_FRAME, d);
                    end
                    4:
                    begin
                        cpu_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        cpu_tick();
                    end
                endcase
            end
        end
    endtask

    // sender holds off until the pipeline is empty, then restarts cold
    task automatic test_drain_pause();
        int round;
        int k;
        for (round = 0; round < 3; round++)
        begin
            for (k = 0; k < 20; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    cpu_write(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                else
                    cpu_tick();
            end
            drain_results();
        end
        repeat (5) cpu_tick();
    endtask

    // closing stretch in both sequencer modes, back to back with no idling
    task automatic test_back_to_back_tail();
        bursts_on = 1'b0;
        cpu_write(SEL_FRAME, 8'h00);         // four-step, sequencer cleared
        cpu_write(SEL_ENABLE, 8'h08);
        cpu_write(SEL_PERIOD, 8'h80);        // short mode, fastest period
        cpu_write(SEL_CONTROL, 8'h01);       // envelope, divider 1, length counts
        cpu_write(SEL_LENGTH, 8'h08);        // longest length
        repeat (80) cpu_tick();
        cpu_write(SEL_FRAME, 8'h80);         // five-step
        cpu_write(SEL_CONTROL, 8'h22);       // looping envelope, halted length
        cpu_write(SEL_PERIOD, 8'h01);
        cpu_write(SEL_LENGTH, 8'h18);
        repeat (60) cpu_tick();
        cpu_write(SEL_CONTROL, 8'h00);       // decay to silence, length runs down
        cpu_write(SEL_LENGTH, 8'h18);
        repeat (60) cpu_tick();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_WRITE;
        reg_select = '0;
        write_data = '0;
        out_ready  = 1'b0;
        bursts_on  = 1'b1;
        hold_left  = 0;
        stall_cycles    = 0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        env_clocks      = 0;
        len_clocks      = 0;
        lfsr_shifts     = 0;

        // predictor matches the power-up state
        ctl_reg        = '0;
        period_load    = '0;
        period_left    = '0;
        length_left    = '0;
        env_start      = 1'b0;
        env_div        = '0;
        env_decay      = '0;
        noise_lfsr     = 15'd1;
        voice_on       = 1'b0;
        five_step_mode = 1'b0;
        seq_cycle      = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_registers();
        test_random_sequences(1450);
        test_drain_pause();
        test_back_to_back_tail();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d results; %0d envelope and %0d length clocks,",
                 items_sent, results_checked, env_clocks, len_clocks);
        $display("%0d lfsr shifts, %0d mismatches, %0d results never arrived",
                 lfsr_shifts, mismatches, voice_expect_q.size());
        if (mismatches == 0 && voice_expect_q.size() == 0)
            $display("PASS noise_channel_with_frame_sequencer");
        else
            $display("FAIL noise_channel_with_frame_sequencer");
        $finish;
    end

endmodule
